[design/dfa_acc_pkg.sv]
`timescale 1ns / 1ps

package dfa_acc_pkg;

	localparam int STATE_W    = 6;
	localparam int SYM_IN_W   = 8;
	localparam int IDX_W      = 8;
	localparam int TCOUNT_W   = 9;
	localparam int MASK_W     = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int VERDICT_W  = 2;
	localparam int OP_W       = 2;

	// states at or above this are never accepting
	localparam int NUM_STATES = 64;

	localparam int MAX_TRANSITIONS_DEF = 256;
	localparam int SYMBOL_BITS_DEF     = 8;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_FEED  = 2'd1,
		OP_EMPTY = 2'd2
	} op_e_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_ACCEPT = 2'd0,
		V_REJECT = 2'd1,
		V_DEAD   = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_STATE = 2'd0,
		CFG_TCOUNT      = 2'd1,
		CFG_ACCEPT_MASK = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} fsm_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [IDX_W-1:0]    entry_index;
		logic [STATE_W-1:0]  from_state;
		logic [SYM_IN_W-1:0] symbol;
		logic [STATE_W-1:0]  to_state;
		logic                last;
	} cmd_t;

	typedef struct packed {
		logic                 accepted;
		logic [VERDICT_W-1:0] verdict;
		logic [STATE_W-1:0]   final_state;
	} res_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [STATE_W-1:0] nxt;
	} tok_t;

	// transition entry load, broadcast to every cell
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   index;
		logic [STATE_W-1:0] from_state;
		logic [STATE_W-1:0] to_state;
	} load_t;

endpackage

[design/dfa_acc_cell.sv]
`timescale 1ns / 1ps

module dfa_acc_cell import dfa_acc_pkg::*; #(
	parameter int IDX   = 0,
	parameter int SYM_W = SYMBOL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  load_t               load,
	input  logic [SYM_W-1:0]    load_sym,
	input  logic [STATE_W-1:0]  key_state,
	input  logic [SYM_W-1:0]    key_sym,
	input  logic [TCOUNT_W-1:0] tcount,
	input  tok_t                tok_in,
	output tok_t                tok_out
);

	logic [STATE_W-1:0] from_q;
	logic [STATE_W-1:0] to_q;
	logic [SYM_W-1:0]   sym_q;
	logic               in_range;
	logic               match;
	tok_t               tok_d;
	tok_t               tok_q;

	always_ff @(posedge clk) begin
		if (load.we && (32'(load.index) == 32'(IDX))) begin
			from_q <= load.from_state;
			to_q   <= load.to_state;
			sym_q  <= load_sym;
		end
	end

	// entries past the configured count are skipped
	assign in_range = 32'(tcount) > 32'(IDX);
	assign match    = in_range && (from_q == key_state) && (sym_q == key_sym);

	always_comb begin
		tok_d = tok_in;
		if (tok_in.valid && !tok_in.hit && match) begin
			tok_d.hit = 1'b1;
			tok_d.nxt = to_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

[design/table_driven_dfa_acceptor_top.sv]
`timescale 1ns / 1ps
// channel   signals                           transfer when
// command   start, busy, cmd (cmd_t)          start && !busy at a rising edge
// result    done, res (res_t)                 done high, one cycle, no stall
// config    cfg_we, cfg_idx, cfg_data         cfg_we high at a rising edge
//
// Load entry, empty-word query, op 3 and symbols of a dead word finish in ST_IDLE and never raise busy.
// A live symbol sends a token down the row of MAX_TRANSITIONS cells, one cell
// per cycle, and busy stays high until the token has left the last cell.
// A result shows up on done/res the cycle after its command finishes.
// Reset clears config, word state and the token row; entries stay undefined.
// The result side cannot stall: done lasts exactly one cycle.

module table_driven_dfa_acceptor_top import dfa_acc_pkg::*; #(
	parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF,
	parameter int SYMBOL_BITS     = SYMBOL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [STATE_W-1:0]  start_state_q;
	logic [TCOUNT_W-1:0] tcount_q;
	logic [MASK_W-1:0]   amask_q;

	fsm_t                   state_q, state_d;
	logic [STATE_W-1:0]     cur_q, cur_d;
	logic                   dead_q, dead_d;
	logic                   inw_q, inw_d;
	logic                   go_q, go_d;
	logic                   done_q, done_d;
	res_t                   res_q, res_d;
	logic [STATE_W-1:0]     key_st_q, key_st_d;
	logic [SYMBOL_BITS-1:0] key_sym_q, key_sym_d;
	logic                   last_q, last_d;

	load_t                  load;
	logic [SYMBOL_BITS-1:0] cmd_sym;
	tok_t                   tok_head;
	tok_t                   tok [MAX_TRANSITIONS];

	function automatic res_t make_res(input logic dead, input logic [STATE_W-1:0] s,
			input logic [MASK_W-1:0] mask);
		res_t r;
		logic acc;
		acc = (32'(s) < 32'(NUM_STATES)) && mask[s];
		if (dead) begin
			r.accepted    = 1'b0;
			r.verdict     = V_DEAD;
			r.final_state = '0;
		end else begin
			r.accepted    = acc;
			r.verdict     = acc ? V_ACCEPT : V_REJECT;
			r.final_state = s;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			tcount_q      <= '0;
			amask_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_START_STATE: begin
					start_state_q <= cfg_data[STATE_W-1:0];
				end
				CFG_TCOUNT: begin
					tcount_q <= cfg_data[TCOUNT_W-1:0];
				end
				CFG_ACCEPT_MASK: begin
					amask_q <= cfg_data[MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cmd_sym = SYMBOL_BITS'(cmd.symbol);

	always_comb begin
		load.we         = (state_q == ST_IDLE) && start && (cmd.op == OP_LOAD);
		load.index      = cmd.entry_index;
		load.from_state = cmd.from_state;
		load.to_state   = cmd.to_state;
	end

	always_comb begin
		tok_head.valid = go_q;
		tok_head.hit   = 1'b0;
		tok_head.nxt   = '0;
	end

	for (genvar i = 0; i < MAX_TRANSITIONS; i++) begin : g_cell
		if (i == 0) begin : g_head
			dfa_acc_cell #(.IDX(i), .SYM_W(SYMBOL_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (load),
				.load_sym (cmd_sym),
				.key_state(key_st_q),
				.key_sym  (key_sym_q),
				.tcount   (tcount_q),
				.tok_in   (tok_head),
				.tok_out  (tok[i])
			);
		end else begin : g_body
			dfa_acc_cell #(.IDX(i), .SYM_W(SYMBOL_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (load),
				.load_sym (cmd_sym),
				.key_state(key_st_q),
				.key_sym  (key_sym_q),
				.tcount   (tcount_q),
				.tok_in   (tok[i-1]),
				.tok_out  (tok[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			dead_q  <= 1'b0;
			inw_q   <= 1'b0;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			dead_q  <= dead_d;
			inw_q   <= inw_d;
			go_q    <= go_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q     <= res_d;
		key_st_q  <= key_st_d;
		key_sym_q <= key_sym_d;
		last_q    <= last_d;
	end

	always_comb begin
		logic [STATE_W-1:0] st;
		logic               dd;
		st        = inw_q ? cur_q : start_state_q;
		dd        = inw_q && dead_q;
		state_d   = state_q;
		cur_d     = cur_q;
		dead_d    = dead_q;
		inw_d     = inw_q;
		go_d      = 1'b0;
		done_d    = 1'b0;
		res_d     = res_q;
		key_st_d  = key_st_q;
		key_sym_d = key_sym_q;
		last_d    = last_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_FEED: begin
							inw_d = 1'b1;
							if (dd) begin
								cur_d  = '0;
								dead_d = 1'b1;
								if (cmd.last) begin
									done_d = 1'b1;
									res_d  = make_res(1'b1, '0, amask_q);
									inw_d  = 1'b0;
								end
							end else begin
								dead_d    = 1'b0;
								key_st_d  = st;
								key_sym_d = cmd_sym;
								last_d    = cmd.last;
								go_d      = 1'b1;
								state_d   = ST_SEARCH;
							end
						end
						OP_EMPTY: begin
							inw_d  = 1'b0;
							done_d = 1'b1;
							res_d  = make_res(1'b0, start_state_q, amask_q);
						end
						default: begin
						end
					endcase
				end
			end
			ST_SEARCH: begin
				// token leaving the last cell carries the first match, if any
				if (tok[MAX_TRANSITIONS-1].valid) begin
					if (tok[MAX_TRANSITIONS-1].hit) begin
						cur_d  = tok[MAX_TRANSITIONS-1].nxt;
						dead_d = 1'b0;
					end else begin
						cur_d  = '0;
						dead_d = 1'b1;
					end
					if (last_q) begin
						done_d = 1'b1;
						res_d  = make_res(!tok[MAX_TRANSITIONS-1].hit,
							tok[MAX_TRANSITIONS-1].nxt, amask_q);
						inw_d  = 1'b0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q == ST_SEARCH);
	assign done = done_q;
	assign res  = res_q;

endmodule

[verif/dfa_verdict_checker.sv]
`timescale 1ns / 1ps

module dfa_verdict_checker import dfa_acc_pkg::*; #(
	parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF,
	parameter int SYMBOL_BITS     = SYMBOL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  cmd_t                  cmd,
	input  logic                  done,
	input  res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatch_count,
	output int                    verdicts_owed
);

	logic [STATE_W-1:0]     tr_from [MAX_TRANSITIONS];
	logic [SYMBOL_BITS-1:0] tr_sym  [MAX_TRANSITIONS];
	logic [STATE_W-1:0]     tr_to   [MAX_TRANSITIONS];

	logic [STATE_W-1:0]  start_reg;
	logic [TCOUNT_W-1:0] count_reg;
	logic [MASK_W-1:0]   mask_reg;

	logic [STATE_W-1:0] cur_state;
	logic               word_dead;
	logic               in_word;

	res_t verdict_q[$];
	int   errs = 0;

	function automatic res_t word_verdict(input logic dead, input logic [STATE_W-1:0] s);
		res_t r;
		logic acc;
		acc = (int'(s) < NUM_STATES) && mask_reg[s];
		if (dead) begin
			r.accepted    = 1'b0;
			r.verdict     = V_DEAD;
			r.final_state = '0;
		end else begin
			r.accepted    = acc;
			r.verdict     = acc ? V_ACCEPT : V_REJECT;
			r.final_state = s;
		end
		return r;
	endfunction

	task automatic step_automaton(input cmd_t c);
		int   n;
		logic hit;
		case (op_e_t'(c.op))
		OP_LOAD: begin
			if (int'(c.entry_index) < MAX_TRANSITIONS) begin
				tr_from[c.entry_index] = c.from_state;
				tr_sym[c.entry_index]  = c.symbol[SYMBOL_BITS-1:0];
				tr_to[c.entry_index]   = c.to_state;
			end
		end
		OP_FEED: begin
			if (!in_word) begin
				cur_state = start_reg;
				word_dead = 1'b0;
				in_word   = 1'b1;
			end
			if (!word_dead) begin
				n   = (int'(count_reg) > MAX_TRANSITIONS) ? MAX_TRANSITIONS : int'(count_reg);
				hit = 1'b0;
				// first matching entry wins
				for (int i = 0; i < MAX_TRANSITIONS; i++) begin
					if (!hit && i < n && tr_from[i] == cur_state &&
							tr_sym[i] == c.symbol[SYMBOL_BITS-1:0]) begin
						cur_state = tr_to[i];
						hit       = 1'b1;
					end
				end
				if (!hit) begin
					word_dead = 1'b1;
					cur_state = '0;
				end
			end
			if (c.last) begin
				verdict_q.push_back(word_verdict(word_dead, cur_state));
				in_word = 1'b0;
			end
		end
		OP_EMPTY: begin
			in_word = 1'b0;
			verdict_q.push_back(word_verdict(1'b0, start_reg));
		end
		default: begin
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			start_reg = '0;
			count_reg = '0;
			mask_reg  = '0;
			cur_state = '0;
			word_dead = 1'b0;
			in_word   = 1'b0;
			verdict_q.delete();
		end else begin
			// retire before predicting: a result and a new transfer can share an edge
			if (done) begin
				if (verdict_q.size() == 0) begin
					$error("unexpected result: accepted=%0d verdict=%0d final_state=%0d",
						res.accepted, res.verdict, res.final_state);
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (res.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, res.accepted);
						errs++;
					end
					if (res.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, res.verdict);
						errs++;
					end
					if (res.final_state !== want.final_state) begin
						$error("final_state: expected %0d, got %0d",
							want.final_state, res.final_state);
						errs++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
				CFG_START_STATE: start_reg = cfg_data[STATE_W-1:0];
				CFG_TCOUNT:      count_reg = cfg_data[TCOUNT_W-1:0];
				CFG_ACCEPT_MASK: mask_reg  = cfg_data[MASK_W-1:0];
				default: begin
				end
				endcase
			end
			if (start && !busy)
				step_automaton(cmd);
		end
		mismatch_count <= errs;
		verdicts_owed  <= verdict_q.size();
	end

endmodule

[verif/table_driven_dfa_acceptor_top_tb.sv]
`timescale 1ns / 1ps

module table_driven_dfa_acceptor_top_tb;
	import dfa_acc_pkg::*;

	localparam int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF;
	localparam int SYMBOL_BITS     = SYMBOL_BITS_DEF;
	// a live symbol walks the whole entry row
	localparam int SETTLE_CYCLES   = MAX_TRANSITIONS + 4;
	localparam int STALL_LIMIT     = 5000;
	localparam int TARGET_ITEMS    = 450;
	localparam int TARGET_VERDICTS = 48;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	cmd_t                  cmd      = '0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  done;
	res_t                  res;
	int                    mismatch_count;
	int                    verdicts_owed;

	int   items_sent   = 0;
	int   verdicts_due = 0;
	int   quiet_cycles = 0;
	logic gaps_on      = 1'b1;

	// state set and alphabet of the automaton loaded for the current phase
	logic [STATE_W-1:0]  states[$];
	logic [SYM_IN_W-1:0] alphabet[$];

	table_driven_dfa_acceptor_top #(
		.MAX_TRANSITIONS(MAX_TRANSITIONS),
		.SYMBOL_BITS(SYMBOL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	dfa_verdict_checker #(
		.MAX_TRANSITIONS(MAX_TRANSITIONS),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.verdicts_owed(verdicts_owed)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic [STATE_W-1:0] from_st,
			input logic [SYM_IN_W-1:0] sym, input logic [STATE_W-1:0] to_st,
			input logic is_last);
		cmd_t c;
		c.op          = op;
		c.entry_index = idx;
		c.from_state  = from_st;
		c.symbol      = sym;
		c.to_state    = to_st;
		c.last        = is_last;
		return c;
	endfunction

	// after a transfer, start and cmd hold until a later negedge lowers start or drives the next command
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = gaps_on ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 1) == 1) begin
			while (busy)
				@(negedge clk);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		items_sent++;
		if (c.op == OP_EMPTY || (c.op == OP_FEED && c.last))
			verdicts_due++;
	endtask

	task automatic feed(input logic [SYM_IN_W-1:0] sym, input logic is_last);
		send_cmd(make_cmd(OP_FEED, 8'($urandom), 6'($urandom), sym, 6'($urandom), is_last));
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [STATE_W-1:0] from_st,
			input logic [SYM_IN_W-1:0] sym, input logic [STATE_W-1:0] to_st);
		send_cmd(make_cmd(OP_LOAD, idx, from_st, sym, to_st, 1'($urandom)));
	endtask

	task automatic query_empty();
		send_cmd(make_cmd(OP_EMPTY, 8'($urandom), 6'($urandom), 8'($urandom), 6'($urandom),
			1'($urandom)));
	endtask

	// wait out every owed verdict; with_tail also covers a search still in flight
	task automatic drain(input bit with_tail);
		@(negedge clk);
		start <= 1'b0;
		while (verdicts_owed != 0)
			@(negedge clk);
		if (with_tail)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_regs(input logic [STATE_W-1:0] s, input logic [TCOUNT_W-1:0] n,
			input logic [MASK_W-1:0] m);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_START_STATE;
		cfg_data <= CFG_DATA_W'(s);
		@(negedge clk);
		cfg_idx  <= CFG_TCOUNT;
		cfg_data <= CFG_DATA_W'(n);
		@(negedge clk);
		cfg_idx  <= CFG_ACCEPT_MASK;
		cfg_data <= m;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic send_word();
		int                  len;
		logic [SYM_IN_W-1:0] sym;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			// empty-word query in mid-word abandons the word
			if (i > 0 && $urandom_range(0, 39) == 0) begin
				query_empty();
				return;
			end
			if ($urandom_range(0, 9) == 0)
				sym = 8'($urandom);
			else
				sym = alphabet[$urandom_range(0, alphabet.size() - 1)];
			feed(sym, i == len - 1);
		end
	endtask

	// complete table over a random state set and alphabet, so most words stay alive
	task automatic run_phase(input bit full_row);
		int                  k;
		int                  m;
		int                  n;
		int                  budget;
		int                  pick;
		logic [STATE_W-1:0]  s;
		logic [SYM_IN_W-1:0] y;
		logic [MASK_W-1:0]   mask;
		logic [TCOUNT_W-1:0] count;
		logic [63:0]         seen_st;
		logic [255:0]        seen_sym;
		cmd_t                ents[$];
		cmd_t                tmp;
		int                  j;

		k = full_row ? 8 : $urandom_range(1, 8);
		m = full_row ? 8 : $urandom_range(1, 6);
		states.delete();
		alphabet.delete();
		ents.delete();
		seen_st  = '0;
		seen_sym = '0;
		while (states.size() < k) begin
			if ($urandom_range(0, 5) == 0)
				s = ($urandom_range(0, 1) == 1) ? '1 : '0;
			else
				s = 6'($urandom);
			if (!seen_st[s]) begin
				seen_st[s] = 1'b1;
				states.push_back(s);
			end
		end
		while (alphabet.size() < m) begin
			if ($urandom_range(0, 5) == 0)
				y = ($urandom_range(0, 1) == 1) ? '1 : '0;
			else
				y = 8'($urandom);
			if (!seen_sym[y]) begin
				seen_sym[y] = 1'b1;
				alphabet.push_back(y);
			end
		end
		foreach (states[a]) begin
			foreach (alphabet[b]) begin
				ents.push_back(make_cmd(OP_LOAD, 8'(ents.size()), states[a], alphabet[b],
					states[$urandom_range(0, k - 1)], 1'($urandom)));
			end
		end
		if (full_row) begin
			while (ents.size() < MAX_TRANSITIONS)
				ents.push_back(make_cmd(OP_LOAD, 8'(ents.size()), 6'($urandom), 8'($urandom),
					6'($urandom), 1'($urandom)));
		end
		n = ents.size();
		for (int i = n - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			tmp     = ents[i];
			ents[i] = ents[j];
			ents[j] = tmp;
		end

		pick = $urandom_range(0, 5);
		if (pick == 0)
			mask = '0;
		else if (pick == 1)
			mask = '1;
		else
			mask = {$urandom, $urandom};
		// the row is fully written from the first random phase on
		pick = $urandom_range(0, 7);
		if (pick == 0)
			count = '0;
		else if (pick == 1)
			count = TCOUNT_W'(MAX_TRANSITIONS);
		else if (pick == 2)
			count = '1;
		else if (pick == 3)
			count = TCOUNT_W'($urandom_range(0, n));
		else
			count = TCOUNT_W'(n);

		drain(1);
		gaps_on = ($urandom_range(0, 3) != 0);
		program_regs(states[$urandom_range(0, k - 1)], count, mask);
		foreach (ents[i])
			send_cmd(ents[i]);

		budget = $urandom_range(20, 45);
		for (int b = 0; b < budget; b++) begin
			if (b == budget / 2)
				drain(0);
			pick = $urandom_range(0, 99);
			if (pick < 80)
				send_word();
			else if (pick < 88)
				query_empty();
			else if (pick < 92)
				send_cmd(make_cmd(2'd3, 8'($urandom), 6'($urandom), 8'($urandom),
					6'($urandom), 1'($urandom)));
			else if (pick < 96)
				load_entry(8'($urandom), 6'($urandom), 8'($urandom), 6'($urandom));
			else
				feed(8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		bit first;
		first = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers: empty list, nothing accepting
		query_empty();
		feed(8'h00, 1'b1);
		send_cmd(cmd_t'('1));
		feed(8'hFF, 1'b0);
		query_empty();

		drain(1);
		program_regs(6'd63, 9'd3, '1);
		load_entry(8'd0, 6'd63, 8'hFF, 6'd0);
		load_entry(8'd1, 6'd0, 8'h00, 6'd63);
		load_entry(8'd2, 6'd63, 8'hFF, 6'd5);
		feed(8'hFF, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'hFF, 1'b1);
		query_empty();
		// dies on the first symbol, then stays dead
		feed(8'h00, 1'b0);
		feed(8'hFF, 1'b0);
		feed(8'hFF, 1'b1);
		feed(8'hFF, 1'b1);

		drain(1);
		program_regs(6'd0, 9'd2, 64'h8000_0000_0000_0000);
		feed(8'h00, 1'b1);
		feed(8'h00, 1'b0);
		feed(8'hFF, 1'b1);
		query_empty();
		// registers change with a word open
		feed(8'h00, 1'b0);
		drain(1);
		program_regs(6'd5, 9'd3, 64'h7FFF_FFFF_FFFF_FFFE);
		feed(8'hFF, 1'b1);

		while (items_sent < TARGET_ITEMS || verdicts_due < TARGET_VERDICTS) begin
			run_phase(first);
			first = 1'b0;
		end

		drain(1);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
